>>> rtl/core/brs_pkg.sv
package brs_pkg;
    localparam int MaxWidthDef  = 256;
    localparam int MaxHeightDef = 256;
    localparam int FracBitsDef  = 8;
    localparam int DimW         = 9;
    localparam int CoordW       = 16;
    localparam int PixW         = 24;
    localparam logic [0:0] RegWidth  = 1'b0;
    localparam logic [0:0] RegHeight = 1'b1;
    localparam logic       OpWrite   = 1'b0;
    localparam logic       OpSample  = 1'b1;
endpackage

>>> rtl/core/brs_ram.sv
module brs_ram #(
    parameter int Width = 24,
    parameter int Depth = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/bicubic_rgb_sampler_core.sv
// Catmull-Rom bicubic sampler over an RGB888 frame store.
// Command channel: i_start with op/pixel/sample fields, taken when o_busy is low.
// op = write: the pixel is stored; no result beat, o_busy stays low.
// op = sample: 16 store reads (one per cycle within each row of four, single-port RAM) fetch the 4x4
//   neighbourhood with clamp-to-edge addressing; horizontal cubics run in a
//   shared multiply-add unit as each row of four arrives, then the vertical cubic
//   per channel. One o_valid beat then carries o_sample_color.
// Each of the 15 cubics runs a coefficient step, then three multiply and
//   round-add pairs; each row adds 4 reads and a wait for the read data; a
//   final state issues the beat. o_busy is high for the whole sample, so a new
//   sample is taken only after the last one ends; a write never raises o_busy.
// Configuration: i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data; index 0 is
//   width, 1 is height; 0 reads as 1, larger than max saturates. Write only idle.
// Reset: synchronous active-low i_rst_n; dimensions return to max, capped at
//   256; the store contents are undefined until written. No clearing pass.
// The result beat lasts one cycle; the receiver cannot stall it.
module bicubic_rgb_sampler_core
    import brs_pkg::*;
#(
    parameter int MAX_WIDTH  = MaxWidthDef,
    parameter int MAX_HEIGHT = MaxHeightDef,
    parameter int FRAC_BITS  = FracBitsDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_op,
    input  logic [7:0]        i_pixel_col,
    input  logic [7:0]        i_pixel_row,
    input  logic [PixW-1:0]   i_pixel_color,
    input  logic [CoordW-1:0] i_sample_x,
    input  logic [CoordW-1:0] i_sample_y,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [0:0]        i_cfg_index,
    input  logic [DimW-1:0]   i_cfg_data,
    output logic              o_valid,
    output logic [PixW-1:0]   o_sample_color
);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int AW    = CW + RW;
    localparam int IW    = (CoordW > FRAC_BITS) ? CoordW - FRAC_BITS : 1;
    localparam int CIW   = (IW > CW ? IW : CW) + 2;
    localparam int RIW   = (IW > RW ? IW : RW) + 2;
    localparam int TW    = FRAC_BITS + 1;
    localparam int VW    = FRAC_BITS + 18;
    localparam int AccW  = VW + TW;
    localparam logic [DimW-1:0] MaxW = DimW'(MAX_WIDTH > 511 ? 511 : MAX_WIDTH);
    localparam logic [DimW-1:0] MaxH = DimW'(MAX_HEIGHT > 511 ? 511 : MAX_HEIGHT);
    localparam logic [DimW-1:0] RstW = DimW'(MAX_WIDTH > 256 ? 256 : MAX_WIDTH);
    localparam logic [DimW-1:0] RstH = DimW'(MAX_HEIGHT > 256 ? 256 : MAX_HEIGHT);

    typedef enum logic [2:0] {
        S_IDLE, S_FETCH, S_COEF, S_MUL, S_ADD, S_STORE, S_DONE
    } t_state;

    t_state                 r_state;
    logic [DimW-1:0]        r_width, r_height;
    logic [IW-1:0]          r_x0, r_y0;
    logic [FRAC_BITS-1:0]   r_tx, r_ty;
    logic [4:0]             r_fcnt;
    logic                   r_rvalid;
    logic [1:0]             r_rvj;
    logic [PixW-1:0]        r_row [4];
    logic signed [AccW-1:0] r_h [3][4];
    logic [1:0]             r_hrow;
    logic                   r_vert;
    logic [1:0]             r_ch;
    logic [1:0]             r_step;
    logic signed [AccW-1:0] r_a, r_b, r_c, r_d, r_v, r_prod;
    logic [PixW-1:0]        r_res;
    logic                   r_valid;
    logic [1:0]             r_pend;

    logic                   we;
    logic [AW-1:0]          addr;
    logic [PixW-1:0]        rdata;
    logic signed [CIW-1:0]  ccol;
    logic signed [RIW-1:0]  crow;
    logic [CW-1:0]          col_c;
    logic [RW-1:0]          row_c;
    logic signed [AccW-1:0] p0, p1, p2, p3, sum, rnd, prod;
    logic signed [VW-1:0]   mulop;
    logic signed [TW-1:0]   tsel;
    logic signed [AccW-1:0] vfin;

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_start;
    assign o_valid     = r_valid;
    assign o_sample_color = r_res;

    // neighbour address
    always_comb begin
        ccol = $signed({2'b0, (CIW-2)'(r_x0)}) + $signed(CIW'({3'b0, r_fcnt[1:0]}))
               - CIW'(1);
        crow = $signed({2'b0, (RIW-2)'(r_y0)}) + $signed(RIW'({3'b0, r_fcnt[3:2]}))
               - RIW'(1);
        if (ccol < 0) col_c = '0;
        else if (ccol > $signed(CIW'(r_width) - CIW'(1))) col_c = CW'(r_width - 1'b1);
        else col_c = CW'(ccol);
        if (crow < 0) row_c = '0;
        else if (crow > $signed(RIW'(r_height) - RIW'(1))) row_c = RW'(r_height - 1'b1);
        else row_c = RW'(crow);
    end

    always_comb begin
        we   = 1'b0;
        addr = {row_c, col_c};
        if (r_state == S_IDLE && i_start && i_op == OpWrite) begin
            addr = {RW'(i_pixel_row), CW'(i_pixel_col)};
            we   = (32'(i_pixel_col) < MAX_WIDTH) && (32'(i_pixel_row) < MAX_HEIGHT);
        end
    end

    brs_ram #(.Width(PixW), .Depth(1 << AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(i_pixel_color),
        .o_rdata(rdata)
    );

    // operand select for the shared cubic unit
    always_comb begin
        if (r_vert) begin
            p0 = r_h[r_ch][0]; p1 = r_h[r_ch][1];
            p2 = r_h[r_ch][2]; p3 = r_h[r_ch][3];
        end else begin
            p0 = AccW'(r_row[0][5'(16 - 8*r_ch) +: 8]) <<< FRAC_BITS;
            p1 = AccW'(r_row[1][5'(16 - 8*r_ch) +: 8]) <<< FRAC_BITS;
            p2 = AccW'(r_row[2][5'(16 - 8*r_ch) +: 8]) <<< FRAC_BITS;
            p3 = AccW'(r_row[3][5'(16 - 8*r_ch) +: 8]) <<< FRAC_BITS;
        end
        tsel  = r_vert ? $signed({1'b0, r_ty}) : $signed({1'b0, r_tx});
        mulop = (r_step == 2'd0) ? VW'(r_a) : VW'(r_v);
        prod  = mulop * tsel;
        rnd   = (r_prod + (AccW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        unique case (r_step)
            2'd0:    sum = rnd + r_b;
            2'd1:    sum = rnd + r_c;
            default: sum = rnd + r_d;
        endcase
        vfin = (sum + (AccW'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= RstW;
            r_height <= RstH;
            r_valid  <= 1'b0;
            r_rvalid <= 1'b0;
        end else begin
            r_valid  <= 1'b0;
            r_rvalid <= (r_state == S_FETCH);
            r_rvj    <= r_fcnt[1:0];
            if (r_rvalid) begin
                r_row[r_rvj] <= rdata;
            end
            if (o_cfg_ready && i_cfg_valid) begin
                unique case (i_cfg_index)
                    RegWidth:  r_width  <= (i_cfg_data == '0) ? DimW'(1) :
                                           (i_cfg_data > MaxW ? MaxW : i_cfg_data);
                    RegHeight: r_height <= (i_cfg_data == '0) ? DimW'(1) :
                                           (i_cfg_data > MaxH ? MaxH : i_cfg_data);
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start && i_op == OpSample) begin
                        r_x0   <= IW'(i_sample_x >> FRAC_BITS);
                        r_y0   <= IW'(i_sample_y >> FRAC_BITS);
                        r_tx   <= i_sample_x[FRAC_BITS-1:0];
                        r_ty   <= i_sample_y[FRAC_BITS-1:0];
                        r_fcnt <= '0;
                        r_hrow <= '0;
                        r_vert <= 1'b0;
                        r_ch   <= '0;
                        r_pend <= 2'd0;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    // issue four reads of one row, then wait for data in S_STORE
                    r_fcnt <= r_fcnt + 1'b1;
                    if (r_fcnt[1:0] == 2'd3) begin
                        r_state <= S_STORE;
                        r_pend  <= 2'd2;
                    end
                end
                S_STORE: begin
                    r_pend <= r_pend - 1'b1;
                    if (r_pend == 2'd0) r_state <= S_COEF;
                end
                S_COEF: begin
                    r_a <= -p0 + 3*p1 - 3*p2 + p3;
                    r_b <= 2*p0 - 5*p1 + 4*p2 - p3;
                    r_c <= p2 - p0;
                    r_d <= 2*p1;
                    r_step  <= 2'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= prod;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (r_step != 2'd2) begin
                        r_v     <= sum;
                        r_step  <= r_step + 1'b1;
                        r_state <= S_MUL;
                    end else if (!r_vert) begin
                        r_h[r_ch][r_hrow] <= (sum + 1) >>> 1;
                        if (r_ch != 2'd2) begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_COEF;
                        end else begin
                            r_ch <= '0;
                            if (r_hrow == 2'd3) begin
                                r_vert  <= 1'b1;
                                r_state <= S_COEF;
                            end else begin
                                r_hrow  <= r_hrow + 1'b1;
                                r_state <= S_FETCH;
                            end
                        end
                    end else begin
                        r_res[5'(16 - 8*r_ch) +: 8] <= (vfin < 0) ? 8'd0 :
                            (vfin > 255 ? 8'd255 : 8'(vfin));
                        if (r_ch != 2'd2) begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_COEF;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
